// ===== hdl/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared constants and types for the indexed min-heap.
// ----------------------------------------------------------------------------
package imh_pkg;

	localparam int CAPACITY_DEF   = 1024;
	localparam int ID_SPACE_DEF   = 1024;
	localparam int PRIO_WIDTH_DEF = 32;

	// field widths of the stream beats
	localparam int ACT_W    = 2;
	localparam int ID_W     = 10;
	localparam int PREQ_W   = 32;
	localparam int STAT_W   = 2;
	localparam int ENTR_W   = 11;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD    = 2'd0,
		ACT_DECKEY = 2'd1,
		ACT_REMOVE = 2'd2,
		ACT_QUERY  = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

endpackage

// ===== hdl/indexed_min_heap.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap
// Binary min-heap of ids with priorities and an id-to-slot position table.
// ----------------------------------------------------------------------------
// One command beat on s_axis (action, item_id, priority_req) gives one
// result beat on m_axis (status, out_id, out_priority, present, entries).
// Actions: add, decrease_key, remove_min and query membership.
// Commands are handled one at a time. The heap lives in two synchronous
// memories with registered read data: a slot memory (id and priority)
// and the position table. The membership check reads the position, then
// the slot. Each sift-up level reads the parent and compares; each
// sift-down level reads both children, picks the smaller and compares.
// Worst case is a remove from a full heap.
// s_tready is high only while the block is idle and no result is pending,
// so the next command beat is taken at the earliest in the cycle after the
// result beat leaves.
// When the receiver stalls, the result stays in the output register and
// no new command is taken. Reset clears the entry count and control
// state; memories need no clearing since only slots below the count and
// position entries checked against the slot memory are trusted.
// ----------------------------------------------------------------------------
module indexed_min_heap
	import imh_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ID_SPACE   = ID_SPACE_DEF,
	parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] action, [11:2] item_id, [43:12] priority_req, [47:44] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [11:2] out_id, [43:12] out_priority, [44] present,
	// [55:45] entries
	output logic [55:0] m_tdata
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
	localparam int PR = PRIO_WIDTH;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_PRD    = 16'h0002, // position read data
		S_SRD    = 16'h0004, // slot at position read data
		S_DEC    = 16'h0008, // decide action
		S_UPRD   = 16'h0010, // sift up: parent read issued
		S_UPCMP  = 16'h0020,
		S_LASTRD = 16'h0040, // remove: last slot read
		S_DNC1   = 16'h0080, // sift down: child1 read
		S_DNC2   = 16'h0100,
		S_DNCMP  = 16'h0200,
		S_ROOTRD = 16'h0400,
		S_DONE   = 16'h0800,
		S_OUT    = 16'h1000,
		S_DNWAIT = 16'h2000
	} state_t;

	state_t state_q;

	// memories
	logic [ID_W-1:0] mem_id  [CAPACITY];
	logic [PR-1:0]   mem_pr  [CAPACITY];
	logic [AW-1:0]   mem_pos [ID_SPACE];

	logic [AW-1:0] s_raddr;
	logic [ID_W-1:0] s_rid_q;
	logic [PR-1:0]   s_rpr_q;
	logic [PW-1:0] p_raddr;
	logic [AW-1:0] p_rdata_q;

	logic          s_we;
	logic [AW-1:0] s_waddr;
	logic [ID_W-1:0] s_wid;
	logic [PR-1:0]   s_wpr;
	logic          p_we;
	logic [PW-1:0] p_waddr;
	logic [AW-1:0] p_wdata;

	always_ff @(posedge clk) begin
		if (s_we) begin
			mem_id[s_waddr] <= s_wid;
			mem_pr[s_waddr] <= s_wpr;
		end
		s_rid_q <= mem_id[s_raddr];
		s_rpr_q <= mem_pr[s_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			mem_pos[p_waddr] <= p_wdata;
		end
		p_rdata_q <= mem_pos[p_raddr];
	end

	// command and working registers
	action_t       act_q;
	logic [ID_W-1:0] id_q;
	logic [PR-1:0]   prio_q;
	logic [CW-1:0] count_q;
	logic          id_ok_q;
	logic          present_q;
	logic [AW-1:0] cur_q;     // current slot of the moving entry
	logic [ID_W-1:0] mid_q;   // moving entry
	logic [PR-1:0]   mpr_q;
	logic [AW-1:0] oth_q;     // parent or picked child slot
	logic [ID_W-1:0] oid_q;
	logic [PR-1:0]   opr_q;
	logic [AW-1:0] c1_q;
	logic [ID_W-1:0] c1id_q;
	logic [PR-1:0]   c1pr_q;
	logic          c2v_q;
	status_t       stat_q;
	logic [ID_W-1:0] rid_q;
	logic [PR-1:0]   rpr_q;
	logic          m_valid_q;
	logic [55:0]   m_data_q;

	logic [ACT_W-1:0]  in_act;
	logic [ID_W-1:0]   in_id;
	logic [PREQ_W-1:0] in_pr;
	assign in_act = s_tdata[1:0];
	assign in_id  = s_tdata[11:2];
	assign in_pr  = s_tdata[43:12];

	assign s_tready = (state_q == S_IDLE) && !m_valid_q;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// child indexes, wide enough to compare against the count
	logic [CW:0] c1_w, c2_w, cur_w;
	assign cur_w = (CW+1)'(cur_q);
	assign c1_w  = {cur_w[CW-1:0], 1'b1};
	assign c2_w  = c1_w + (CW+1)'(1);

	logic [AW-1:0] par_w;
	assign par_w = AW'((cur_q - AW'(1)) >> 1);

	logic [PR-1:0] in_pr_n;
	assign in_pr_n = PR'(in_pr);

	// other entry moves into the current slot: parent down or child up
	logic move_w;
	assign move_w = (act_q == ACT_REMOVE) ? (opr_q < mpr_q) : (opr_q > mpr_q);

	// combinational memory control
	always_comb begin
		s_raddr = cur_q;
		p_raddr = PW'(id_q);
		s_we    = 1'b0;
		s_waddr = cur_q;
		s_wid   = mid_q;
		s_wpr   = mpr_q;
		p_we    = 1'b0;
		p_waddr = PW'(mid_q);
		p_wdata = cur_q;
		unique case (state_q)
			S_IDLE:   p_raddr = PW'(in_id);
			S_PRD:    s_raddr = p_rdata_q;
			S_DEC:    s_raddr = '0;
			S_UPRD:   s_raddr = par_w;
			S_DNC1:   s_raddr = AW'(c1_w);
			S_DNC2:   s_raddr = AW'(c2_w);
			S_ROOTRD: s_raddr = AW'(count_q);
			S_DNWAIT: begin
				if (move_w) begin
					s_we    = 1'b1;
					s_waddr = cur_q;
					s_wid   = oid_q;
					s_wpr   = opr_q;
					p_we    = 1'b1;
					p_waddr = PW'(oid_q);
					p_wdata = cur_q;
				end
			end
			S_DONE: begin
				s_we = 1'b1;
				p_we = 1'b1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						act_q   <= action_t'(in_act);
						id_q    <= in_id;
						prio_q  <= in_pr_n;
						id_ok_q <= (32'(in_id) < ID_SPACE);
						stat_q  <= ST_OK;
						rid_q   <= '0;
						rpr_q   <= '0;
						present_q <= 1'b0;
						state_q <= S_PRD;
					end
				end
				S_PRD: begin
					cur_q   <= p_rdata_q;
					present_q <= id_ok_q && (CW'(p_rdata_q) < count_q);
					state_q <= S_SRD;
				end
				S_SRD: begin
					present_q <= present_q && (s_rid_q == id_q);
					mpr_q   <= s_rpr_q;
					state_q <= S_DEC;
				end
				S_DEC: begin
					mid_q <= id_q;
					unique case (act_q)
						ACT_ADD: begin
							if (!id_ok_q) begin
								stat_q  <= ST_ABSENT;
								state_q <= S_OUT;
							end else if (present_q) begin
								state_q <= S_OUT;
							end else if (32'(count_q) >= CAPACITY) begin
								stat_q  <= ST_FULL;
								state_q <= S_OUT;
							end else begin
								cur_q   <= AW'(count_q);
								mpr_q   <= prio_q;
								count_q <= count_q + CW'(1);
								state_q <= S_UPRD;
							end
						end
						ACT_DECKEY: begin
							if (!present_q) begin
								stat_q  <= ST_ABSENT;
								state_q <= S_OUT;
							end else if (prio_q <= mpr_q) begin
								mpr_q   <= prio_q;
								state_q <= S_UPRD;
							end else begin
								state_q <= S_OUT;
							end
						end
						ACT_REMOVE: begin
							if (count_q == '0) begin
								stat_q  <= ST_EMPTY;
								state_q <= S_OUT;
							end else begin
								cur_q   <= '0;
								count_q <= count_q - CW'(1);
								state_q <= S_ROOTRD;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_UPRD: begin
					if (cur_q == '0) begin
						state_q <= S_DONE;
					end else begin
						oth_q   <= par_w;
						state_q <= S_UPCMP;
					end
				end
				S_UPCMP: begin
					oid_q <= s_rid_q;
					opr_q <= s_rpr_q;
					state_q <= S_DNWAIT;
				end
				// compare with registered operands, step one level on a move
				S_DNWAIT: begin
					if (move_w) begin
						cur_q   <= oth_q;
						state_q <= (act_q == ACT_REMOVE) ? S_DNC1 : S_UPRD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ROOTRD: begin
					// root data from the read issued while deciding
					rid_q <= s_rid_q;
					rpr_q <= s_rpr_q;
					state_q <= S_LASTRD;
				end
				S_LASTRD: begin
					mid_q <= s_rid_q;
					mpr_q <= s_rpr_q;
					state_q <= S_DNC1;
				end
				S_DNC1: begin
					c1_q  <= AW'(c1_w);
					c2v_q <= (c2_w < (CW+1)'(count_q));
					if (c1_w >= (CW+1)'(count_q)) begin
						state_q <= (count_q == '0) ? S_OUT : S_DONE;
					end else begin
						state_q <= S_DNC2;
					end
				end
				S_DNC2: begin
					c1id_q  <= s_rid_q;
					c1pr_q  <= s_rpr_q;
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					// pick child2 on ties, child1 only when strictly less
					if (c2v_q && !(c1pr_q < s_rpr_q)) begin
						oth_q <= AW'(c1_q + AW'(1));
						oid_q <= s_rid_q;
						opr_q <= s_rpr_q;
					end else begin
						oth_q <= c1_q;
						oid_q <= c1id_q;
						opr_q <= c1pr_q;
					end
					state_q <= S_DNWAIT;
				end
				S_DONE: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					m_data_q  <= {ENTR_W'(count_q), present_q && (act_q == ACT_QUERY),
						PREQ_W'(rpr_q), rid_q, stat_q};
					m_valid_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
